// ===== hdl/cbs_pkg.sv =====
// Package for the cubic Bezier split pipeline: coordinate and split types,
// the input and result item structs, and the interpolation helpers.
// No dependencies.
package cbs_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int T_W     = 16;
  // A difference of two coordinates times an unsigned split, kept exact.
  localparam int PROD_W  = COORD_W + 1 + T_W + 2;
  // Register stages in the split pipeline.
  localparam int NSTG    = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [T_W:0]       tfrac_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam tfrac_t T_ONE  = tfrac_t'(1) << T_W;
  localparam tfrac_t T_HALF = tfrac_t'(1) << (T_W - 1);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_ctrl_x;
    coord_t start_ctrl_y;
    coord_t end_ctrl_x;
    coord_t end_ctrl_y;
    coord_t end_x;
    coord_t end_y;
    tfrac_t split_t;
    logic   keep_outer;
  } in_item_t;

  typedef struct packed {
    coord_t mid_x;
    coord_t mid_y;
    coord_t mid_prev_x;
    coord_t mid_prev_y;
    coord_t mid_next_x;
    coord_t mid_next_y;
    coord_t new_start_ctrl_x;
    coord_t new_start_ctrl_y;
    coord_t new_end_ctrl_x;
    coord_t new_end_ctrl_y;
  } out_item_t;

  // First half of an interpolation: (b - a) * t, exact.
  function automatic prod_t diff_mul(coord_t a, coord_t b, tfrac_t t);
    logic signed [COORD_W:0] d;
    logic signed [T_W+1:0]   ts;
    d  = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    ts = $signed({1'b0, t});
    return prod_t'(d) * prod_t'(ts);
  endfunction

  // Second half: a + floor(p / 2^T_W). The result lies between the two
  // end values, so the low bits are the whole answer.
  function automatic coord_t lerp_fin(coord_t a, prod_t p);
    prod_t s;
    s = prod_t'(a) + (p >>> T_W);
    return s[COORD_W-1:0];
  endfunction

endpackage

// ===== hdl/cubic_bezier_split_top.sv =====
// Cubic Bezier split by de Casteljau subdivision, six register stages.
// Depends on cbs_pkg for the item structs and interpolation helpers.
//
// Each de Casteljau level is a multiply stage followed by an add stage, and
// those six stages lie between an accepted input item and its result item.
// Throughput: one item per cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous) empties every stage; no data is cleared.
module cubic_bezier_split_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cbs_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbs_pkg::out_item_t  out_data_o
);

  // Each stage holds a valid bit. A stage loads whenever it is empty or the
  // stage after it moves on, so bubbles collapse and a stalled output only
  // backs up the pipeline once every stage is full.
  logic [cbs_pkg::NSTG-1:0] vld_q;
  logic [cbs_pkg::NSTG-1:0] rdy;

  always_comb begin
    rdy[cbs_pkg::NSTG-1] = !vld_q[cbs_pkg::NSTG-1] || !out_stall_i;
    for (int i = cbs_pkg::NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < cbs_pkg::NSTG; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Input unpacking. Index 0 is x, index 1 is y. A split above one is
  // clamped to one.
  cbs_pkg::coord_t pt [4][2];
  cbs_pkg::tfrac_t t_in;

  always_comb begin
    pt[0][0] = in_data_i.start_x;
    pt[0][1] = in_data_i.start_y;
    pt[1][0] = in_data_i.start_ctrl_x;
    pt[1][1] = in_data_i.start_ctrl_y;
    pt[2][0] = in_data_i.end_ctrl_x;
    pt[2][1] = in_data_i.end_ctrl_y;
    pt[3][0] = in_data_i.end_x;
    pt[3][1] = in_data_i.end_y;
    t_in = (in_data_i.split_t > cbs_pkg::T_ONE) ? cbs_pkg::T_ONE : in_data_i.split_t;
  end

  // Stage 1: first level products. The bases are P0, P1 and P2; P1 and P2 also
  // serve as the original controls for the keep case.
  cbs_pkg::coord_t base1_q [3][2];
  cbs_pkg::prod_t  prod1_q [3][2];
  cbs_pkg::tfrac_t t1_q;
  logic            keep1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 2; k++) begin
          base1_q[j][k] <= pt[j][k];
          prod1_q[j][k] <= cbs_pkg::diff_mul(pt[j][k], pt[j+1][k], t_in);
        end
      end
      t1_q    <= t_in;
      keep1_q <= in_data_i.keep_outer;
    end
  end

  // Stage 2: first level sums a01, a12, a23, and the outer controls chosen.
  cbs_pkg::coord_t lvl1_d   [3][2];
  cbs_pkg::coord_t lvl1_q   [3][2];
  cbs_pkg::coord_t outer2_q [2][2];
  cbs_pkg::tfrac_t t2_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 2; k++) begin
        lvl1_d[j][k] = cbs_pkg::lerp_fin(base1_q[j][k], prod1_q[j][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int k = 0; k < 2; k++) begin
        for (int j = 0; j < 3; j++) begin
          lvl1_q[j][k] <= lvl1_d[j][k];
        end
        outer2_q[0][k] <= keep1_q ? base1_q[1][k] : lvl1_d[0][k];
        outer2_q[1][k] <= keep1_q ? base1_q[2][k] : lvl1_d[2][k];
      end
      t2_q <= t1_q;
    end
  end

  // Stage 3: second level products.
  cbs_pkg::coord_t base3_q  [2][2];
  cbs_pkg::prod_t  prod3_q  [2][2];
  cbs_pkg::coord_t outer3_q [2][2];
  cbs_pkg::tfrac_t t3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          base3_q[j][k]  <= lvl1_q[j][k];
          prod3_q[j][k]  <= cbs_pkg::diff_mul(lvl1_q[j][k], lvl1_q[j+1][k], t2_q);
          outer3_q[j][k] <= outer2_q[j][k];
        end
      end
      t3_q <= t2_q;
    end
  end

  // Stage 4: second level sums b0 and b1, the controls beside the split.
  cbs_pkg::coord_t lvl2_q   [2][2];
  cbs_pkg::coord_t outer4_q [2][2];
  cbs_pkg::tfrac_t t4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          lvl2_q[j][k]   <= cbs_pkg::lerp_fin(base3_q[j][k], prod3_q[j][k]);
          outer4_q[j][k] <= outer3_q[j][k];
        end
      end
      t4_q <= t3_q;
    end
  end

  // Stage 5: third level product.
  cbs_pkg::coord_t lvl2c_q  [2][2];
  cbs_pkg::prod_t  prod5_q  [2];
  cbs_pkg::coord_t outer5_q [2][2];

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int k = 0; k < 2; k++) begin
        prod5_q[k] <= cbs_pkg::diff_mul(lvl2_q[0][k], lvl2_q[1][k], t4_q);
        for (int j = 0; j < 2; j++) begin
          lvl2c_q[j][k]  <= lvl2_q[j][k];
          outer5_q[j][k] <= outer4_q[j][k];
        end
      end
    end
  end

  // Stage 6: split point and the output register.
  cbs_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      out_q.mid_x            <= cbs_pkg::lerp_fin(lvl2c_q[0][0], prod5_q[0]);
      out_q.mid_y            <= cbs_pkg::lerp_fin(lvl2c_q[0][1], prod5_q[1]);
      out_q.mid_prev_x       <= lvl2c_q[0][0];
      out_q.mid_prev_y       <= lvl2c_q[0][1];
      out_q.mid_next_x       <= lvl2c_q[1][0];
      out_q.mid_next_y       <= lvl2c_q[1][1];
      out_q.new_start_ctrl_x <= outer5_q[0][0];
      out_q.new_start_ctrl_y <= outer5_q[0][1];
      out_q.new_end_ctrl_x   <= outer5_q[1][0];
      out_q.new_end_ctrl_y   <= outer5_q[1][1];
    end
  end

  assign out_valid_o = vld_q[cbs_pkg::NSTG-1];
  assign out_data_o  = out_q;

  // The input backs up only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q && out_stall_i))
    else $error("input stalled while the pipeline has a bubble");

  // The split carried into the first stage never exceeds one.
  a_t_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (t1_q <= cbs_pkg::T_ONE))
    else $error("split parameter not clamped");

  // A stage that cannot move on keeps its item and its data.
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && !rdy[3]) |=> (vld_q[3] && $stable(t4_q)))
    else $error("stalled stage lost its item");

  // An item in stage three moves into stage four whenever stage four loads.
  a_half_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && rdy[3]) |=> vld_q[3])
    else $error("item dropped between stages");

endmodule

// ===== test/tb_cubic_bezier_split_top.sv =====
// Testbench for cubic_bezier_split_top: a directed table followed by random segments,
// each result compared with a de Casteljau split computed here. Depends on cbs_pkg.
module tb_cubic_bezier_split_top;
  import cbs_pkg::*;

  // Number of random segments after the directed table.
  localparam int RAND_ITEMS  = 1250;
  // Cycle budget for the whole run.
  localparam int CYCLE_LIMIT = 200000;
  // Wait after the last expected result, so that a stray result is still caught.
  localparam int DRAIN_CYCLES = 12;

  // Corner points used by the directed rows whose results are typed in.
  localparam coord_t P0X = 32'h0001_0000, P0Y = 32'hFFFE_0000;
  localparam coord_t P1X = 32'h0003_8000, P1Y = 32'h0004_0000;
  localparam coord_t P2X = 32'hFFF8_0000, P2Y = 32'h0010_0000;
  localparam coord_t P3X = 32'h0020_0000, P3Y = 32'hFFC0_0000;
  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } seg_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  out_item_t split_q[$];   // expected split results, oldest first
  seg_row_t  seg_table[$]; // directed segments
  int        err_cnt   = 0;
  int        cycle_cnt = 0;

  cubic_bezier_split_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // One linear interpolation step: a + floor((b - a) * t / 2^T_W). The product
  // of a 33-bit difference and a 17-bit split fits a longint, and the
  // arithmetic shift gives the floor directly, negative values included.
  function automatic longint interp(longint a, longint b, longint t);
    longint prod;
    prod = (b - a) * t;
    return a + (prod >>> T_W);
  endfunction

  // Three de Casteljau levels on one axis. When keep is set the outer
  // controls are passed through instead of being shortened.
  function automatic void split_axis(input coord_t c0, c1, c2, c3, input longint t,
                                     input bit keep, output coord_t m, prv, nxt,
                                     output coord_t ns, ne);
    longint a01, a12, a23, b0, b1;
    a01 = interp(longint'(c0), longint'(c1), t);
    a12 = interp(longint'(c1), longint'(c2), t);
    a23 = interp(longint'(c2), longint'(c3), t);
    b0  = interp(a01, a12, t);
    b1  = interp(a12, a23, t);
    m   = coord_t'(interp(b0, b1, t));
    prv = coord_t'(b0);
    nxt = coord_t'(b1);
    ns  = keep ? c1 : coord_t'(a01);
    ne  = keep ? c2 : coord_t'(a23);
  endfunction

  // Expected result for one segment. A split above one behaves as one.
  function automatic out_item_t split_segment(in_item_t it);
    out_item_t r;
    longint    t;
    t = (it.split_t > T_ONE) ? longint'(T_ONE) : longint'(it.split_t);
    split_axis(it.start_x, it.start_ctrl_x, it.end_ctrl_x, it.end_x, t, it.keep_outer,
               r.mid_x, r.mid_prev_x, r.mid_next_x, r.new_start_ctrl_x, r.new_end_ctrl_x);
    split_axis(it.start_y, it.start_ctrl_y, it.end_ctrl_y, it.end_y, t, it.keep_outer,
               r.mid_y, r.mid_prev_y, r.mid_next_y, r.new_start_ctrl_y, r.new_end_ctrl_y);
    return r;
  endfunction

  function automatic in_item_t mk_seg(coord_t x0, y0, x1, y1, x2, y2, x3, y3,
                                      tfrac_t t, logic keep);
    in_item_t it;
    it.start_x      = x0;
    it.start_y      = y0;
    it.start_ctrl_x = x1;
    it.start_ctrl_y = y1;
    it.end_ctrl_x   = x2;
    it.end_ctrl_y   = y2;
    it.end_x        = x3;
    it.end_y        = y3;
    it.split_t      = t;
    it.keep_outer   = keep;
    return it;
  endfunction

  // Result built from five points: split point, its two controls, and the
  // new outer controls.
  function automatic out_item_t mk_res(coord_t mx, my, px, py, nx, ny,
                                       coord_t sx, sy, ex, ey);
    out_item_t r;
    r.mid_x            = mx;
    r.mid_y            = my;
    r.mid_prev_x       = px;
    r.mid_prev_y       = py;
    r.mid_next_x       = nx;
    r.mid_next_y       = ny;
    r.new_start_ctrl_x = sx;
    r.new_start_ctrl_y = sy;
    r.new_end_ctrl_x   = ex;
    r.new_end_ctrl_y   = ey;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, out_item_t want);
    seg_row_t row;
    row.stim  = it;
    row.typed = typed;
    row.want  = want;
    seg_table.insert(seg_table.size(), row);
  endfunction

  // The directed table. Rows with a typed result are those where the answer
  // follows at once: t = 0 returns the start side, t = one returns the end
  // side, and a degenerate segment returns its single point everywhere.
  function automatic void build_table();
    // All zero, at both ends of the split range.
    add_row(mk_seg('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b1, '0);
    add_row(mk_seg('0, '0, '0, '0, '0, '0, '0, '0, T_ONE, 1'b1), 1'b1, '0);
    // Split at zero: the split point sits on the start point.
    add_row(mk_seg(P0X, P0Y, P1X, P1Y, P2X, P2Y, P3X, P3Y, '0, 1'b0), 1'b1,
            mk_res(P0X, P0Y, P0X, P0Y, P1X, P1Y, P0X, P0Y, P2X, P2Y));
    add_row(mk_seg(P0X, P0Y, P1X, P1Y, P2X, P2Y, P3X, P3Y, '0, 1'b1), 1'b1,
            mk_res(P0X, P0Y, P0X, P0Y, P1X, P1Y, P1X, P1Y, P2X, P2Y));
    // Split at one: the split point sits on the end point.
    add_row(mk_seg(P0X, P0Y, P1X, P1Y, P2X, P2Y, P3X, P3Y, T_ONE, 1'b0), 1'b1,
            mk_res(P3X, P3Y, P2X, P2Y, P3X, P3Y, P1X, P1Y, P3X, P3Y));
    // Split beyond one saturates, up to the largest encodable split.
    add_row(mk_seg(P0X, P0Y, P1X, P1Y, P2X, P2Y, P3X, P3Y, '1, 1'b0), 1'b1,
            mk_res(P3X, P3Y, P2X, P2Y, P3X, P3Y, P1X, P1Y, P3X, P3Y));
    add_row(mk_seg(P0X, P0Y, P1X, P1Y, P2X, P2Y, P3X, P3Y, tfrac_t'(T_ONE + 1), 1'b1),
            1'b1, mk_res(P3X, P3Y, P2X, P2Y, P3X, P3Y, P1X, P1Y, P2X, P2Y));
    // Degenerate segments at the coordinate extremes.
    add_row(mk_seg(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, T_HALF, 1'b0),
            1'b1, mk_res(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                         C_MAX, C_MAX));
    add_row(mk_seg(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 17'd12345, 1'b1),
            1'b1, mk_res(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                         C_MIN, C_MIN));
    // The remaining rows go through the predictor.
    add_row(mk_seg(P0X, P0Y, P1X, P1Y, P2X, P2Y, P3X, P3Y, T_HALF, 1'b0), 1'b0, '0);
    add_row(mk_seg(P0X, P0Y, P1X, P1Y, P2X, P2Y, P3X, P3Y, T_HALF, 1'b1), 1'b0, '0);
    // Full-range swings between the extremes.
    add_row(mk_seg(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, T_HALF, 1'b0),
            1'b0, '0);
    add_row(mk_seg(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, 17'd1, 1'b0),
            1'b0, '0);
    add_row(mk_seg(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX,
                   tfrac_t'(T_ONE - 1), 1'b1), 1'b0, '0);
    // Rounding toward minus infinity on small negative steps.
    add_row(mk_seg('0, '0, '1, '1, 32'sd1, -32'sd3, -32'sd2, 32'sd5, 17'd1, 1'b0), 1'b0, '0);
    add_row(mk_seg('0, 32'sd7, '1, -32'sd7, '1, 32'sd1, '0, -32'sd1, tfrac_t'(T_ONE - 1),
                   1'b0), 1'b0, '0);
    add_row(mk_seg(-32'sd5, 32'sd3, 32'sd2, -32'sd9, -32'sd1, 32'sd4, 32'sd6, -32'sd2,
                   17'd21845, 1'b0), 1'b0, '0);
  endfunction

  // Coordinates lean on the extremes and on small values near zero, where
  // the floor rounding is easiest to get wrong.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return C_MIN;
      1: return C_MAX;
      2, 3, 4, 5: return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic in_item_t rand_segment();
    in_item_t it;
    coord_t   cx, cy;
    it = mk_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord(), '0, 1'b0);
    // Now and then all four points coincide.
    if ($urandom_range(0, 9) == 0) begin
      cx = it.start_x;
      cy = it.start_y;
      it = mk_seg(cx, cy, cx, cy, cx, cy, cx, cy, '0, 1'b0);
    end
    case ($urandom_range(0, 9))
      0: it.split_t = T_ONE + tfrac_t'($urandom_range(1, (1 << T_W) - 1));
      1: begin
        case ($urandom_range(0, 2))
          0: it.split_t = '0;
          1: it.split_t = T_HALF;
          default: it.split_t = T_ONE;
        endcase
      end
      default: it.split_t = tfrac_t'($urandom_range(0, 1 << T_W));
    endcase
    it.keep_outer = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Present one item and hold it until the block takes it, then record what
  // it should produce. Valid stays high on return so that a following item
  // goes out back to back.
  task automatic send_segment(input in_item_t it, input out_item_t want);
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    split_q.insert(split_q.size(), want);
  endtask

  task automatic check_field(input string name, input coord_t want, input coord_t got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Receiver side: bits 9:8 of the cycle count step the stall pattern through no
  // stall, light random stall, a fixed rhythm and heavy random stall.
  always @(posedge clk_i) begin
    case (cycle_cnt[9:8])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2'd2: out_stall_i <= ((cycle_cnt % 7) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (split_q.size() == 0) begin
        err_cnt++;
        $display("%0t: no result expected, actual %h", $time, out_data_o);
      end else begin
        exp_res = split_q.pop_front();
        check_field("mid_x", exp_res.mid_x, out_data_o.mid_x);
        check_field("mid_y", exp_res.mid_y, out_data_o.mid_y);
        check_field("mid_prev_x", exp_res.mid_prev_x, out_data_o.mid_prev_x);
        check_field("mid_prev_y", exp_res.mid_prev_y, out_data_o.mid_prev_y);
        check_field("mid_next_x", exp_res.mid_next_x, out_data_o.mid_next_x);
        check_field("mid_next_y", exp_res.mid_next_y, out_data_o.mid_next_y);
        check_field("new_start_ctrl_x", exp_res.new_start_ctrl_x,
                    out_data_o.new_start_ctrl_x);
        check_field("new_start_ctrl_y", exp_res.new_start_ctrl_y,
                    out_data_o.new_start_ctrl_y);
        check_field("new_end_ctrl_x", exp_res.new_end_ctrl_x, out_data_o.new_end_ctrl_x);
        check_field("new_end_ctrl_y", exp_res.new_end_ctrl_y, out_data_o.new_end_ctrl_y);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sender side: items go out in bursts of random length, with random gaps
  // between bursts and some bursts run back to back with no gap at all.
  initial begin
    in_item_t  it;
    out_item_t want;
    int        idx;
    int        total;
    int        burst;
    int        gap;

    build_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idx   = 0;
    total = seg_table.size() + RAND_ITEMS;
    while (idx < total) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && idx < total; k++) begin
        if (idx < seg_table.size()) begin
          it   = seg_table[idx].stim;
          want = seg_table[idx].typed ? seg_table[idx].want : split_segment(it);
        end else begin
          it   = rand_segment();
          want = split_segment(it);
        end
        send_segment(it, want);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // Wait for every expected result, then a few more cycles so that any
    // stray result still gets caught.
    while (split_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
